// ===== hdl/mwem_pkg.sv =====
// shared types and constants for the microwire eeprom master
`timescale 1ns / 1ps

package mwem_pkg;

    localparam int DATA_W = 16;
    localparam int WADDR_W = 8;

    // command opcodes, start bit included
    localparam logic [2:0] OP_READ  = 3'b110;
    localparam logic [2:0] OP_WRITE = 3'b101;
    // enable / disable words, aligned so the low four bits are address bits
    localparam logic [7:0] OP_EWEN = 8'h4f;
    localparam logic [7:0] OP_EWDS = 8'h40;

    localparam logic [3:0]  ADDR_BITS_RST  = 4'd6;
    localparam logic [3:0]  ADDR_BITS_MIN  = 4'd6;
    localparam logic [7:0]  HALF_TICKS_RST = 8'd1;
    localparam logic [15:0] POLL_LIMIT_RST = 16'd10000;

    localparam logic [1:0] CFG_ADDRESS_BITS    = 2'd0;
    localparam logic [1:0] CFG_HALF_BIT_TICKS  = 2'd1;
    localparam logic [1:0] CFG_BUSY_POLL_LIMIT = 2'd2;

    typedef enum logic [2:0] {
        SEQ_IDLE      = 3'd0,
        SEQ_READ      = 3'd1,
        SEQ_POLL_PRE  = 3'd2,
        SEQ_EWEN      = 3'd3,
        SEQ_WRITE     = 3'd4,
        SEQ_POLL_POST = 3'd5,
        SEQ_EWDS      = 3'd6,
        SEQ_POLL_LAST = 3'd7
    } t_step;

    typedef enum logic [1:0] {
        PH_SETUP    = 2'd0,
        PH_LOW      = 2'd1,
        PH_HIGH     = 2'd2,
        PH_DESELECT = 2'd3
    } t_phase;

    typedef struct packed {
        logic [3:0]  address_bits;
        logic [7:0]  half_bit_ticks;
        logic [15:0] busy_poll_limit;
    } t_cfg;

    typedef struct packed {
        logic              chip_select;
        logic              shift_clock;
        logic              eeprom_din;
        logic              idle;
        logic              done_res;
        logic [DATA_W-1:0] read_data;
        logic [DATA_W-1:0] write_poll_ticks;
        logic              timed_out;
    } t_result;

endpackage

// ===== hdl/microwire_eeprom_master_top.sv =====
// top level of the microwire serial eeprom master
// Each input word is one timing tick of the eeprom pin sequence and yields exactly one
// output word with the pin levels and status for that tick. One word is taken every clock
// while o_in_stall is low; each word passes through an input register, one pass of the
// sequencer logic and an output register. While a result waits in the output register the
// input register takes one more word and then stalls. A read costs 2 + 2*(address_bits + 20)
// phases, each phase half_bit_ticks ticks; a busy poll costs one tick per data-out sample up
// to busy_poll_limit.
// Configuration writes are taken at any time and should be issued while the block is idle.
`timescale 1ns / 1ps

module microwire_eeprom_master_top #(
    parameter int MAX_ADDRESS_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_start_req,
    input  logic                          i_mode,
    input  logic [mwem_pkg::WADDR_W-1:0]  i_word_address,
    input  logic [mwem_pkg::DATA_W-1:0]   i_write_data,
    input  logic                          i_eeprom_dout,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_chip_select,
    output logic                          o_shift_clock,
    output logic                          o_eeprom_din,
    output logic                          o_idle,
    output logic                          o_done_res,
    output logic [mwem_pkg::DATA_W-1:0]   o_read_data,
    output logic [mwem_pkg::DATA_W-1:0]   o_write_poll_ticks,
    output logic                          o_timed_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [15:0]                   i_cfg_data
);
    import mwem_pkg::*;

    t_cfg               r_cfg;
    logic               r_in_valid;
    logic               r_start_req;
    logic               r_mode;
    logic [WADDR_W-1:0] r_word_address;
    logic [DATA_W-1:0]  r_write_data;
    logic               r_eeprom_dout;
    logic               r_out_valid;
    t_result            r_out;
    t_result            w_res;
    logic               w_adv;
    logic               w_in_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.address_bits    <= ADDR_BITS_RST;
            r_cfg.half_bit_ticks  <= HALF_TICKS_RST;
            r_cfg.busy_poll_limit <= POLL_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ADDRESS_BITS:    r_cfg.address_bits    <= i_cfg_data[3:0];
                CFG_HALF_BIT_TICKS:  r_cfg.half_bit_ticks  <= i_cfg_data[7:0];
                CFG_BUSY_POLL_LIMIT: r_cfg.busy_poll_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance when a word sits in the input register and the output register frees up
    assign w_adv      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_in_take  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_start_req    <= i_start_req;
            r_mode         <= i_mode;
            r_word_address <= i_word_address;
            r_write_data   <= i_write_data;
            r_eeprom_dout  <= i_eeprom_dout;
        end
    end

    mwem_seq #(
        .MAX_ADDRESS_BITS(MAX_ADDRESS_BITS)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (w_adv),
        .i_cfg          (r_cfg),
        .i_start_req    (r_start_req),
        .i_mode         (r_mode),
        .i_word_address (r_word_address),
        .i_write_data   (r_write_data),
        .i_eeprom_dout  (r_eeprom_dout),
        .o_res          (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_chip_select      = r_out.chip_select;
    assign o_shift_clock      = r_out.shift_clock;
    assign o_eeprom_din       = r_out.eeprom_din;
    assign o_idle             = r_out.idle;
    assign o_done_res         = r_out.done_res;
    assign o_read_data        = r_out.read_data;
    assign o_write_poll_ticks = r_out.write_poll_ticks;
    assign o_timed_out        = r_out.timed_out;

endmodule

// ===== hdl/mwem_seq.sv =====
// command sequencer: advances the serial pin sequence by one tick per word
`timescale 1ns / 1ps

module mwem_seq #(
    parameter int MAX_ADDRESS_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  mwem_pkg::t_cfg                i_cfg,
    input  logic                          i_start_req,
    input  logic                          i_mode,
    input  logic [mwem_pkg::WADDR_W-1:0]  i_word_address,
    input  logic [mwem_pkg::DATA_W-1:0]   i_write_data,
    input  logic                          i_eeprom_dout,
    output mwem_pkg::t_result             o_res
);
    import mwem_pkg::*;

    localparam int SHIFT_W = MAX_ADDRESS_BITS + 20;
    localparam int BL_W    = $clog2(SHIFT_W + 1);
    localparam int IDX_W   = $clog2(SHIFT_W);
    localparam logic [3:0] MAX_AB = 4'(MAX_ADDRESS_BITS);

    t_step               r_step, c_step, n_step;
    t_phase              r_phase, c_phase, p_phase, n_phase;
    logic [7:0]          r_ticks, c_ticks, p_ticks, n_ticks;
    logic [BL_W-1:0]     r_bits, c_bits, p_bits, n_bits;
    logic [SHIFT_W-1:0]  r_shift, c_shift, n_shift;
    logic [DATA_W-1:0]   r_in_shift, c_in_shift, p_in_shift;
    logic [DATA_W-1:0]   r_poll, c_poll, p_poll, n_poll;
    logic [DATA_W-1:0]   r_data, c_data;
    logic [WADDR_W-1:0]  r_addr, c_addr;
    logic [DATA_W-1:0]   r_read_word, n_read_word;
    logic [DATA_W-1:0]   r_result, c_result, n_result;
    logic                r_timeout, c_timeout, p_timeout;

    logic                w_start, w_finish, w_reload, w_is_poll, w_bit;
    logic [3:0]          w_ab;
    logic [7:0]          w_ht, w_tick_inc;
    logic [DATA_W-1:0]   w_lim, w_poll_inc;
    logic [BL_W-1:0]     w_bits_dec;
    t_step               w_start_step;

    function automatic logic [SHIFT_W-1:0] f_load_shift(
        input t_step               step,
        input logic [3:0]          ab,
        input logic [WADDR_W-1:0]  addr,
        input logic [DATA_W-1:0]   data
    );
        logic [SHIFT_W-1:0] ad;
        ad = SHIFT_W'(addr) & ~({SHIFT_W{1'b1}} << ab);
        case (step)
            SEQ_READ:  f_load_shift = ((SHIFT_W'(OP_READ) << ab) | ad) << 16;
            SEQ_WRITE: f_load_shift = (((SHIFT_W'(OP_WRITE) << ab) | ad) << 16)
                                      | SHIFT_W'(data);
            SEQ_EWEN:  f_load_shift = SHIFT_W'(OP_EWEN) << (ab - 4'd4);
            SEQ_EWDS:  f_load_shift = SHIFT_W'(OP_EWDS) << (ab - 4'd4);
            default:   f_load_shift = '0;
        endcase
    endfunction

    function automatic logic [BL_W-1:0] f_load_bits(
        input t_step      step,
        input logic [3:0] ab
    );
        case (step)
            SEQ_READ, SEQ_WRITE: f_load_bits = BL_W'(ab) + BL_W'(20);
            SEQ_EWEN, SEQ_EWDS:  f_load_bits = BL_W'(ab) + BL_W'(4);
            default:             f_load_bits = '0;
        endcase
    endfunction

    // effective settings
    always_comb begin
        if (i_cfg.address_bits < ADDR_BITS_MIN) begin
            w_ab = ADDR_BITS_MIN;
        end else if (i_cfg.address_bits > MAX_AB) begin
            w_ab = MAX_AB;
        end else begin
            w_ab = i_cfg.address_bits;
        end
        w_ht  = (i_cfg.half_bit_ticks == '0) ? 8'd1 : i_cfg.half_bit_ticks;
        w_lim = (i_cfg.busy_poll_limit == '0) ? 16'd1 : i_cfg.busy_poll_limit;
    end

    // state as seen after a start on this tick
    assign w_start      = (r_step == SEQ_IDLE) && i_start_req;
    assign w_start_step = i_mode ? SEQ_POLL_PRE : SEQ_READ;

    always_comb begin
        c_addr     = w_start ? i_word_address : r_addr;
        c_data     = w_start ? i_write_data : r_data;
        c_step     = w_start ? w_start_step : r_step;
        c_phase    = w_start ? PH_SETUP : r_phase;
        c_ticks    = w_start ? 8'd0 : r_ticks;
        c_poll     = w_start ? '0 : r_poll;
        c_bits     = w_start ? f_load_bits(w_start_step, w_ab) : r_bits;
        c_shift    = w_start ? f_load_shift(w_start_step, w_ab, i_word_address,
                                            i_write_data) : r_shift;
        c_in_shift = w_start ? '0 : r_in_shift;
        c_timeout  = w_start ? 1'b0 : r_timeout;
        c_result   = (w_start && i_mode) ? '0 : r_result;
    end

    assign w_is_poll = (c_step == SEQ_POLL_PRE) || (c_step == SEQ_POLL_POST)
                    || (c_step == SEQ_POLL_LAST);
    assign w_bit = (c_bits != '0) ? c_shift[IDX_W'(c_bits - BL_W'(1))] : 1'b0;
    assign w_tick_inc = c_ticks + 8'd1;
    assign w_poll_inc = c_poll + 16'd1;
    assign w_bits_dec = (c_bits != '0) ? c_bits - BL_W'(1) : '0;

    // one tick of the current step
    always_comb begin
        p_phase    = c_phase;
        p_ticks    = c_ticks;
        p_bits     = c_bits;
        p_in_shift = c_in_shift;
        p_poll     = c_poll;
        p_timeout  = c_timeout;
        w_finish   = 1'b0;
        if (w_is_poll) begin
            if (i_eeprom_dout) begin
                w_finish = 1'b1;
            end else if (w_poll_inc >= w_lim) begin
                p_poll    = w_lim;
                p_timeout = 1'b1;
                w_finish  = 1'b1;
            end else begin
                p_poll = w_poll_inc;
            end
        end else if (c_step != SEQ_IDLE) begin
            if (w_tick_inc >= w_ht) begin
                p_ticks = 8'd0;
                case (c_phase)
                    PH_SETUP: begin
                        p_phase = (c_bits != '0) ? PH_LOW : PH_DESELECT;
                    end
                    PH_LOW: begin
                        p_phase = PH_HIGH;
                    end
                    PH_HIGH: begin
                        p_in_shift = {c_in_shift[DATA_W-2:0], i_eeprom_dout};
                        p_bits     = w_bits_dec;
                        p_phase    = (w_bits_dec != '0) ? PH_LOW : PH_DESELECT;
                    end
                    default: begin
                        w_finish = 1'b1;
                    end
                endcase
            end else begin
                p_ticks = w_tick_inc;
            end
        end
    end

    // next state
    always_comb begin
        n_step = c_step;
        if (w_finish) begin
            case (c_step)
                SEQ_POLL_PRE:  n_step = SEQ_EWEN;
                SEQ_EWEN:      n_step = SEQ_WRITE;
                SEQ_WRITE:     n_step = SEQ_POLL_POST;
                SEQ_POLL_POST: n_step = SEQ_EWDS;
                SEQ_EWDS:      n_step = SEQ_POLL_LAST;
                default:       n_step = SEQ_IDLE;
            endcase
        end
    end

    // a finished step loads the next one
    assign w_reload = w_finish && (n_step != SEQ_IDLE);

    always_comb begin
        n_phase = w_reload ? PH_SETUP : p_phase;
        n_ticks = w_reload ? 8'd0 : p_ticks;
        n_poll  = w_reload ? '0 : p_poll;
        n_bits  = w_reload ? f_load_bits(n_step, w_ab) : p_bits;
        n_shift = w_reload ? f_load_shift(n_step, w_ab, c_addr, c_data) : c_shift;
        n_read_word = (w_finish && (c_step == SEQ_READ)) ? c_in_shift : r_read_word;
        n_result    = (w_finish && (c_step == SEQ_POLL_POST)) ? p_poll : c_result;
    end

    // pin levels and status for this tick
    always_comb begin
        o_res.chip_select = 1'b0;
        o_res.shift_clock = 1'b0;
        o_res.eeprom_din  = 1'b0;
        if (w_is_poll) begin
            o_res.chip_select = 1'b1;
        end else if (c_step != SEQ_IDLE) begin
            case (c_phase)
                PH_SETUP: begin
                    o_res.chip_select = 1'b1;
                    o_res.shift_clock = 1'b1;
                end
                PH_LOW: begin
                    o_res.chip_select = 1'b1;
                    o_res.eeprom_din  = w_bit;
                end
                PH_HIGH: begin
                    o_res.chip_select = 1'b1;
                    o_res.shift_clock = 1'b1;
                    o_res.eeprom_din  = w_bit;
                end
                default: begin
                    o_res.chip_select = 1'b0;
                end
            endcase
        end
        o_res.idle             = (n_step == SEQ_IDLE);
        o_res.done_res         = w_finish && (n_step == SEQ_IDLE);
        o_res.read_data        = n_read_word;
        o_res.write_poll_ticks = n_result;
        o_res.timed_out        = p_timeout;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= SEQ_IDLE;
            r_phase     <= PH_SETUP;
            r_ticks     <= '0;
            r_bits      <= '0;
            r_shift     <= '0;
            r_in_shift  <= '0;
            r_poll      <= '0;
            r_data      <= '0;
            r_addr      <= '0;
            r_read_word <= '0;
            r_result    <= '0;
            r_timeout   <= 1'b0;
        end else if (i_adv) begin
            r_step      <= n_step;
            r_phase     <= n_phase;
            r_ticks     <= n_ticks;
            r_bits      <= n_bits;
            r_shift     <= n_shift;
            r_in_shift  <= p_in_shift;
            r_poll      <= n_poll;
            r_data      <= c_data;
            r_addr      <= c_addr;
            r_read_word <= n_read_word;
            r_result    <= n_result;
            r_timeout   <= p_timeout;
        end
    end

endmodule
